[rtl/es2utc_pkg.sv]
// Package for the epoch seconds to UTC calendar core.
// Holds the shared constants, the month result type and the month start table.
// Depends on nothing; used by es2utc_month and epoch_seconds_to_utc_date_core.
package es2utc_pkg;

    // Reciprocal multipliers.
    // Each quotient is (x * MUL) >> SHIFT, which is exact over the range that reaches it.
    localparam logic [24:0] DAY_MUL   = 25'd25451659;  // x / 675, x < 2**24
    localparam int          DAY_SHIFT = 34;
    localparam logic [14:0] CYC_MUL   = 15'd22967;     // x / 1461, x < 25221
    localparam int          CYC_SHIFT = 25;
    localparam logic [12:0] HOUR_MUL  = 13'd4661;      // x / 225, x < 5400
    localparam int          HOUR_SHIFT = 20;
    localparam logic [15:0] WEEK_MUL  = 16'd37450;     // x / 7, x < 24860
    localparam int          WEEK_SHIFT = 18;
    localparam logic [11:0] MIN_MUL   = 12'd2185;      // x / 60, x < 3600
    localparam int          MIN_SHIFT = 17;

    localparam logic [9:0]  DAY_SECS_HI = 10'd675;    // 86400 / 128
    localparam logic [10:0] CYCLE_DAYS  = 11'd1461;
    localparam logic [8:0]  YEAR_DAYS   = 9'd365;
    localparam logic [11:0] HOUR_SECS   = 12'd3600;
    localparam logic [5:0]  MIN_SECS    = 6'd60;
    localparam logic [2:0]  WEEK_DAYS   = 3'd7;
    localparam logic [2:0]  EPOCH_WDAY  = 3'd4;       // 1970-01-01 was a Thursday
    localparam logic [6:0]  BASE_YEAR   = 7'd69;      // cycles start in 1969
    localparam logic [3:0]  MONTHS      = 4'd12;
    localparam logic [3:0]  MARCH       = 4'd2;

    typedef struct packed {
        logic [3:0] month_index;
        logic [4:0] day_of_month;
    } month_res_t;

    // First day of year of each month in a common year.
    function automatic logic [8:0] month_first_day(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

[rtl/es2utc_month.sv]
// Month lookup: turns a day of year and a leap flag into month and day of month.
// Twelve parallel compares against the month start table of es2utc_pkg.
// Depends on es2utc_pkg.
module es2utc_month
    import es2utc_pkg::*;
(
    input  logic [8:0]  day_of_year,
    input  logic        leap,
    output month_res_t  res
);

    logic [11:0] hit;
    logic [8:0]  start [12];
    logic [8:0]  sel_start;
    logic [3:0]  sel_month;
    logic [8:0]  dom_full;

    always_comb
    begin
        for (int m = 0; m < 12; m++)
        begin
            start[m] = month_first_day(4'(m)) +
                       9'((leap && (4'(m) >= MARCH)) ? 1 : 0);
            hit[m]   = (start[m] <= day_of_year);
        end
    end

    // The last month whose first day is not after the day of year wins.
    always_comb
    begin
        sel_month = '0;
        sel_start = '0;
        for (int m = 0; m < 12; m++)
        begin
            if (hit[m])
            begin
                sel_month = 4'(m);
                sel_start = start[m];
            end
        end
    end

    assign dom_full = day_of_year - sel_start + 9'd1;

    assign res.month_index  = sel_month;
    assign res.day_of_month = dom_full[4:0];

endmodule

[rtl/epoch_seconds_to_utc_date_core.sv]
// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00 UTC
// into a UTC calendar date and time of day. The core is a six-stage pipeline
// that takes one word per cycle; the depth is set by the chain of reciprocal
// multiplies (days, then four-year cycles, hours and weekday, then minutes)
// each followed by a remainder stage. When the output word is not taken the
// whole pipeline holds.
// Counts above 2147483647 give valid_res 0 and all other fields 0.
// Depends on es2utc_pkg and es2utc_month.
module epoch_seconds_to_utc_date_core
    import es2utc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        epoch_valid,
    output logic        epoch_ready,
    input  logic [31:0] epoch_seconds,
    output logic        date_valid,
    input  logic        date_ready,
    output logic        valid_res,
    output logic [7:0]  years_since_1900,
    output logic [3:0]  month_index,
    output logic [4:0]  day_of_month,
    output logic [4:0]  hour_of_day,
    output logic [5:0]  minute_of_hour,
    output logic [5:0]  second_of_minute,
    output logic [2:0]  weekday,
    output logic [8:0]  day_of_year
);

    localparam int STAGES = 6;

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;
    logic              advance;

    assign advance     = !vld_reg[STAGES-1] || date_ready;
    assign epoch_ready = advance;
    assign date_valid  = vld_reg[STAGES-1];
    assign vld_next    = {vld_reg[STAGES-2:0], epoch_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= vld_next;
        end
    end

    // Stage 1: days = seconds / 86400, taken as (seconds >> 7) / 675.
    logic        ok1_reg;
    logic [14:0] day_q1_reg;
    logic [23:0] x1_reg;
    logic [6:0]  lo1_reg;
    logic [48:0] day_prod;
    logic [14:0] day_q1_next;

    assign day_prod    = 49'(epoch_seconds[30:7]) * 49'(DAY_MUL);
    assign day_q1_next = day_prod[DAY_SHIFT+14:DAY_SHIFT];

    // Stage 2: time of day from the remainder.
    logic        ok2_reg;
    logic [14:0] days2_reg;
    logic [16:0] tod2_reg;
    logic [23:0] rem2_full;
    logic [16:0] tod2_next;

    assign rem2_full = x1_reg - 24'(day_q1_reg) * 24'(DAY_SECS_HI);
    assign tod2_next = {rem2_full[9:0], lo1_reg};

    // Stage 3: four-year cycle, hour and weekday quotients.
    logic        ok3_reg;
    logic [14:0] f3_reg;
    logic [4:0]  cyc3_reg;
    logic [16:0] tod3_reg;
    logic [4:0]  hour3_reg;
    logic [14:0] dp3_reg;
    logic [11:0] wq3_reg;
    logic [14:0] f3_next;
    logic [14:0] dp3_next;
    logic [29:0] cyc_prod;
    logic [25:0] hour_prod;
    logic [30:0] week_prod;

    assign f3_next   = days2_reg + 15'(YEAR_DAYS);
    assign dp3_next  = days2_reg + 15'(EPOCH_WDAY);
    assign cyc_prod  = 30'(f3_next) * 30'(CYC_MUL);
    assign hour_prod = 26'(tod2_reg[16:4]) * 26'(HOUR_MUL);
    assign week_prod = 31'(dp3_next) * 31'(WEEK_MUL);

    // Stage 4: remainders of the stage 3 quotients.
    logic        ok4_reg;
    logic [4:0]  cyc4_reg;
    logic [10:0] rem4_reg;
    logic [11:0] tsec4_reg;
    logic [4:0]  hour4_reg;
    logic [2:0]  wd4_reg;
    logic [14:0] rem4_full;
    logic [16:0] tsec4_full;
    logic [14:0] wd4_full;

    assign rem4_full  = f3_reg - 15'(cyc3_reg) * 15'(CYCLE_DAYS);
    assign tsec4_full = tod3_reg - 17'(hour3_reg) * 17'(HOUR_SECS);
    assign wd4_full   = dp3_reg - 15'(wq3_reg) * 15'(WEEK_DAYS);

    // Stage 5: year within the cycle, day of year and minute.
    logic        ok5_reg;
    logic [7:0]  year5_reg;
    logic [8:0]  doy5_reg;
    logic        leap5_reg;
    logic [5:0]  min5_reg;
    logic [11:0] tsec5_reg;
    logic [4:0]  hour5_reg;
    logic [2:0]  wd5_reg;
    logic [1:0]  yr5;
    logic [10:0] doy5_full;
    logic [7:0]  year5_next;
    logic [23:0] min_prod;

    // The fourth year of each cycle is the leap year, so its extra day
    // lands at the end of the cycle.
    always_comb
    begin
        if (rem4_reg >= 11'(3 * 365))
        begin
            yr5 = 2'd3;
        end
        else if (rem4_reg >= 11'(2 * 365))
        begin
            yr5 = 2'd2;
        end
        else if (rem4_reg >= 11'(YEAR_DAYS))
        begin
            yr5 = 2'd1;
        end
        else
        begin
            yr5 = 2'd0;
        end
    end

    assign doy5_full  = rem4_reg - 11'(yr5) * 11'(YEAR_DAYS);
    assign year5_next = 8'(BASE_YEAR) + {1'b0, cyc4_reg, 2'b00} + 8'(yr5);
    assign min_prod   = 24'(tsec4_reg) * 24'(MIN_MUL);

    // Stage 6: month search, second, and the output register.
    month_res_t  mres;
    logic [11:0] sec6_full;

    es2utc_month u_month (
        .day_of_year (doy5_reg),
        .leap        (leap5_reg),
        .res         (mres)
    );

    assign sec6_full = tsec5_reg - 12'(min5_reg) * 12'(MIN_SECS);

    logic        valid_res_reg;
    logic [7:0]  year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  dom_reg;
    logic [4:0]  hour_reg;
    logic [5:0]  minute_reg;
    logic [5:0]  second_reg;
    logic [2:0]  wday_reg;
    logic [8:0]  doy_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ok1_reg    <= !epoch_seconds[31];
            day_q1_reg <= day_q1_next;
            x1_reg     <= epoch_seconds[30:7];
            lo1_reg    <= epoch_seconds[6:0];

            ok2_reg    <= ok1_reg;
            days2_reg  <= day_q1_reg;
            tod2_reg   <= tod2_next;

            ok3_reg    <= ok2_reg;
            f3_reg     <= f3_next;
            cyc3_reg   <= cyc_prod[CYC_SHIFT+4:CYC_SHIFT];
            tod3_reg   <= tod2_reg;
            hour3_reg  <= hour_prod[HOUR_SHIFT+4:HOUR_SHIFT];
            dp3_reg    <= dp3_next;
            wq3_reg    <= week_prod[WEEK_SHIFT+11:WEEK_SHIFT];

            ok4_reg    <= ok3_reg;
            cyc4_reg   <= cyc3_reg;
            rem4_reg   <= rem4_full[10:0];
            tsec4_reg  <= tsec4_full[11:0];
            hour4_reg  <= hour3_reg;
            wd4_reg    <= wd4_full[2:0];

            ok5_reg    <= ok4_reg;
            year5_reg  <= year5_next;
            doy5_reg   <= doy5_full[8:0];
            leap5_reg  <= (yr5 == 2'd3);
            min5_reg   <= min_prod[MIN_SHIFT+5:MIN_SHIFT];
            tsec5_reg  <= tsec4_reg;
            hour5_reg  <= hour4_reg;
            wd5_reg    <= wd4_reg;

            valid_res_reg <= ok5_reg;
            year_reg      <= ok5_reg ? year5_reg : '0;
            month_reg     <= ok5_reg ? mres.month_index : '0;
            dom_reg       <= ok5_reg ? mres.day_of_month : '0;
            hour_reg      <= ok5_reg ? hour5_reg : '0;
            minute_reg    <= ok5_reg ? min5_reg : '0;
            second_reg    <= ok5_reg ? sec6_full[5:0] : '0;
            wday_reg      <= ok5_reg ? wd5_reg : '0;
            doy_reg       <= ok5_reg ? doy5_reg : '0;
        end
    end

    assign valid_res        = valid_res_reg;
    assign years_since_1900 = year_reg;
    assign month_index      = month_reg;
    assign day_of_month     = dom_reg;
    assign hour_of_day      = hour_reg;
    assign minute_of_hour   = minute_reg;
    assign second_of_minute = second_reg;
    assign weekday          = wday_reg;
    assign day_of_year      = doy_reg;

    // An accepted word always occupies the first stage on the next cycle.
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        epoch_valid && epoch_ready |=> vld_reg[0])
        else $error("accepted word did not enter the pipeline");

    // Out-of-range counts give an all-zero result.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        date_valid && !valid_res |-> years_since_1900 == '0 && month_index == '0 &&
            day_of_month == '0 && hour_of_day == '0 && day_of_year == '0)
        else $error("invalid result carries nonzero fields");

    // A valid date lies within the calendar.
    a_date: assert property (@(posedge clk) disable iff (!rst_n)
        date_valid && valid_res |-> month_index < MONTHS && day_of_month != '0 &&
            years_since_1900 >= 8'd70 && years_since_1900 <= 8'd138)
        else $error("date out of range");

    // A valid time of day and weekday lie within range.
    a_time: assert property (@(posedge clk) disable iff (!rst_n)
        date_valid && valid_res |-> hour_of_day <= 5'd23 && minute_of_hour <= 6'd59 &&
            second_of_minute <= 6'd59 && weekday <= 3'd6)
        else $error("time of day or weekday out of range");

endmodule
